FILE: rtl/artdmx_pkg.sv
// shared types and constants for the art-net dmx packet receiver
package artdmx_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 512;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CH_IDX_W = 9;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_UNIVERSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 1'b1;

  localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 10'd512;
  localparam logic [WORD_W-1:0] OPCODE_DMX        = 16'h5000;
  localparam logic [WORD_W-1:0] OPCODE_POLL       = 16'h2000;
  localparam logic [WORD_W-1:0] OPCODE_POLL_REPLY = 16'h2100;
  localparam logic [WORD_W-1:0] PROTOCOL_VERSION  = 16'd14;
  localparam logic [POS_W-1:0]  MIN_SIZE          = 10'd10;
  localparam logic [POS_W-1:0]  DATA_OFFSET       = 10'd18;
  localparam logic [POS_W-1:0]  POS_LIMIT         = 10'd1023;

  // "Art-Net" followed by a zero byte
  localparam logic [BYTE_W-1:0] IDENT [8] = '{
    8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
  };

  typedef enum logic [2:0] {
    OC_TOO_SHORT  = 3'd0,
    OC_BAD_HEADER = 3'd1,
    OC_WRONG_UNIV = 3'd2,
    OC_DMX_TAKEN  = 3'd3,
    OC_POLL       = 3'd4,
    OC_POLL_REPLY = 3'd5,
    OC_UNKNOWN    = 3'd6
  } outcome_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              end_of_packet;
  } in_beat_t;

  typedef struct packed {
    kind_e               kind;
    logic [CH_IDX_W-1:0] channel_index;
    logic [BYTE_W-1:0]   channel_value;
    outcome_e            outcome;
    logic                any_changed;
    logic                last_result;
  } out_beat_t;

  // header parser view of the current beat
  typedef struct packed {
    logic     cand;     // data byte that goes to the channel compare
    outcome_e outcome;  // packet outcome if this beat is the last
  } hdr_info_t;

endpackage

FILE: rtl/artdmx_ram.sv
// generic single write port ram with registered read
module artdmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/artdmx_hdr.sv
// art-net header parser: byte position, header fields and outcome decode
module artdmx_hdr #(
  parameter int unsigned MAX_CHANNELS = artdmx_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  artdmx_pkg::in_beat_t          beat_i,
  input  logic [artdmx_pkg::WORD_W-1:0] listen_universe_i,
  input  logic [artdmx_pkg::CNT_W-1:0]  channel_count_i,
  output artdmx_pkg::hdr_info_t         info_o,
  output logic [IDX_W-1:0]              idx_o
);
  import artdmx_pkg::*;

  localparam logic [POS_W-1:0] POS_IDENT_END = 10'd8;
  localparam logic [POS_W-1:0] POS_OP_LO     = 10'd8;
  localparam logic [POS_W-1:0] POS_OP_HI     = 10'd9;
  localparam logic [POS_W-1:0] POS_VER_HI    = 10'd10;
  localparam logic [POS_W-1:0] POS_VER_LO    = 10'd11;
  localparam logic [POS_W-1:0] POS_UNIV_LO   = 10'd14;
  localparam logic [POS_W-1:0] POS_UNIV_HI   = 10'd15;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 10'd16;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 10'd17;
  localparam logic [CNT_W-1:0] MAX_CNT       = CNT_W'(MAX_CHANNELS);

  logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
  logic              hdr_ok_q, hdr_ok_d, hdr_ok_nx;
  logic [WORD_W-1:0] opcode_q, opcode_d, opcode_nx;
  logic [WORD_W-1:0] version_q, version_d, version_nx;
  logic [WORD_W-1:0] univ_q, univ_d, univ_nx;
  logic [WORD_W-1:0] len_q, len_d, len_nx;
  logic [BYTE_W-1:0] b;
  logic [POS_W-1:0]  data_i;
  logic [CNT_W-1:0]  cnt_eff;
  logic              data_cand;
  outcome_e          oc_sel;

  assign b = beat_i.payload_byte;

  always_comb begin
    hdr_ok_nx  = hdr_ok_q;
    opcode_nx  = opcode_q;
    version_nx = version_q;
    univ_nx    = univ_q;
    len_nx     = len_q;
    if (pos_q < POS_IDENT_END) begin
      if (b != IDENT[pos_q[2:0]]) begin
        hdr_ok_nx = 1'b0;
      end
    end else if (pos_q == POS_OP_LO) begin
      opcode_nx = {opcode_q[15:8], b};
    end else if (pos_q == POS_OP_HI) begin
      opcode_nx = {b, opcode_q[7:0]};
    end else if (pos_q == POS_VER_HI) begin
      version_nx = {b, version_q[7:0]};
    end else if (pos_q == POS_VER_LO) begin
      version_nx = {version_q[15:8], b};
    end else if (pos_q == POS_UNIV_LO) begin
      univ_nx = {univ_q[15:8], b};
    end else if (pos_q == POS_UNIV_HI) begin
      univ_nx = {b, univ_q[7:0]};
    end else if (pos_q == POS_LEN_HI) begin
      len_nx = {b, len_q[7:0]};
    end else if (pos_q == POS_LEN_LO) begin
      len_nx = {len_q[15:8], b};
    end
  end

  assign pos_inc = (pos_q == POS_LIMIT) ? pos_q : pos_q + 10'd1;

  // outcome from the header as it stands after this byte
  always_comb begin
    priority if (pos_inc <= MIN_SIZE) begin
      oc_sel = OC_TOO_SHORT;
    end else if (!hdr_ok_nx || version_nx != PROTOCOL_VERSION) begin
      oc_sel = OC_BAD_HEADER;
    end else if (opcode_nx == OPCODE_DMX) begin
      oc_sel = (univ_nx == listen_universe_i) ? OC_DMX_TAKEN : OC_WRONG_UNIV;
    end else if (opcode_nx == OPCODE_POLL) begin
      oc_sel = OC_POLL;
    end else if (opcode_nx == OPCODE_POLL_REPLY) begin
      oc_sel = OC_POLL_REPLY;
    end else begin
      oc_sel = OC_UNKNOWN;
    end
  end

  // data bytes only touch header state that is already settled
  assign data_i  = pos_q - DATA_OFFSET;
  assign cnt_eff = (channel_count_i > MAX_CNT) ? MAX_CNT : channel_count_i;
  assign data_cand = (pos_q >= DATA_OFFSET) && hdr_ok_q &&
                     (version_q == PROTOCOL_VERSION) && (opcode_q == OPCODE_DMX) &&
                     (univ_q == listen_universe_i) &&
                     ({6'd0, data_i} < len_q) && (data_i < cnt_eff);
  assign info_o = '{cand: data_cand, outcome: oc_sel};
  assign idx_o  = data_i[IDX_W-1:0];

  always_comb begin
    pos_d     = pos_q;
    hdr_ok_d  = hdr_ok_q;
    opcode_d  = opcode_q;
    version_d = version_q;
    univ_d    = univ_q;
    len_d     = len_q;
    if (accept_i) begin
      if (beat_i.end_of_packet) begin
        pos_d     = '0;
        hdr_ok_d  = 1'b1;
        opcode_d  = '0;
        version_d = '0;
        univ_d    = '0;
        len_d     = '0;
      end else begin
        pos_d     = pos_inc;
        hdr_ok_d  = hdr_ok_nx;
        opcode_d  = opcode_nx;
        version_d = version_nx;
        univ_d    = univ_nx;
        len_d     = len_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_ok_q  <= 1'b1;
      opcode_q  <= '0;
      version_q <= '0;
      univ_q    <= '0;
      len_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      hdr_ok_q  <= hdr_ok_d;
      opcode_q  <= opcode_d;
      version_q <= version_d;
      univ_q    <= univ_d;
      len_q     <= len_d;
    end
  end

endmodule

FILE: rtl/artnet_dmx_packet_receiver.sv
// art-net artdmx receiver top level: header parse, channel store compare, result output
// path: a result beat reaches out_o through the compare stage registers, then the output register
// throughput: one input beat per cycle if out_stall_i is low; a beat causing a channel
//   write and a report sends both in turn and stalls the input until the report goes out
// reset: header state, config registers and handshakes clear at once; the channel
//   store is not swept, a fill mark makes entries never reached read as zero
module artnet_dmx_packet_receiver #(
  parameter int unsigned MAX_CHANNELS = artdmx_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beats
  input  artdmx_pkg::in_beat_t              in_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  // result beats
  output artdmx_pkg::out_beat_t             out_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  // config writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [artdmx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [artdmx_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import artdmx_pkg::*;

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned HW_W  = $clog2(MAX_CHANNELS + 1);

  // config registers
  logic [WORD_W-1:0] listen_q;
  logic [CNT_W-1:0]  ccount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= '0;
      ccount_q <= CHANNEL_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LISTEN_UNIVERSE: listen_q <= cfg_data_i;
        CFG_CHANNEL_COUNT:   ccount_q <= cfg_data_i[CNT_W-1:0];
        default:             listen_q <= listen_q;
      endcase
    end
  end

  // header parser
  logic       accept;
  hdr_info_t  info;
  logic [IDX_W-1:0] idx;

  assign accept = in_valid_i && !in_stall_o;

  artdmx_hdr #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_hdr (
    .clk_i,
    .rst_ni,
    .accept_i         (accept),
    .beat_i           (in_i),
    .listen_universe_i(listen_q),
    .channel_count_i  (ccount_q),
    .info_o           (info),
    .idx_o            (idx)
  );

  // fill mark: entries at or above it were never reached and count as zero
  logic [HW_W-1:0] fill_q, fill_d;
  logic            fresh;

  assign fresh = (HW_W'(idx) == fill_q);

  always_comb begin
    fill_d = fill_q;
    if (accept && info.cand && fresh) begin
      fill_d = fill_q + HW_W'(1);
    end
  end

  // compare stage, store read lands here together with the beat
  logic              s1_valid_q, s1_valid_d;
  logic              s1_wr_sent_q, s1_wr_sent_d;
  logic              changed_q, changed_d;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_cand_q;
  logic              s1_fresh_q;
  logic              s1_last_q;
  logic [IDX_W-1:0]  s1_idx_q;
  outcome_e          s1_outcome_q;

  logic [BYTE_W-1:0] stored;
  logic              have_write, need_write, need_report;
  logic              out_free, push, s1_done, mem_we;

  artdmx_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk_i,
    .wr_en_i  (mem_we),
    .wr_addr_i(s1_idx_q),
    .wr_data_i(s1_byte_q),
    .rd_en_i  (accept && info.cand),
    .rd_addr_i(idx),
    .rd_data_o(stored)
  );

  // indexes rise through a packet, so the write never meets a read of its entry
  assign have_write  = s1_cand_q && (s1_fresh_q ? (s1_byte_q != '0) : (stored != s1_byte_q));
  assign need_write  = have_write && !s1_wr_sent_q;
  assign need_report = s1_last_q;

  logic out_valid_q;
  out_beat_t out_q, out_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign push     = s1_valid_q && (need_write || need_report) && out_free;
  // done when nothing is left to send or the final beat goes out now
  assign s1_done  = s1_valid_q &&
                    (!(need_write || need_report) || (out_free && !(need_write && need_report)));
  // fresh entries are written even when unchanged so the fill mark stays true
  assign mem_we   = s1_done && s1_cand_q && (s1_fresh_q || have_write);

  assign in_stall_o = s1_valid_q && !s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    s1_wr_sent_d = s1_wr_sent_q;
    if (s1_done) begin
      s1_wr_sent_d = 1'b0;
    end else if (push && need_write) begin
      s1_wr_sent_d = 1'b1;
    end
  end

  always_comb begin
    changed_d = changed_q;
    if (s1_done) begin
      changed_d = s1_last_q ? 1'b0 : (changed_q || have_write);
    end
  end

  // result beat build
  always_comb begin
    out_d = out_q;
    if (push) begin
      if (need_write) begin
        out_d.kind          = KIND_WRITE;
        out_d.channel_index = CH_IDX_W'(s1_idx_q);
        out_d.channel_value = s1_byte_q;
        out_d.outcome       = OC_TOO_SHORT;
        out_d.any_changed   = 1'b0;
        out_d.last_result   = !s1_last_q;
      end else begin
        out_d.kind          = KIND_REPORT;
        out_d.channel_index = '0;
        out_d.channel_value = '0;
        out_d.outcome       = s1_outcome_q;
        out_d.any_changed   = (s1_outcome_q == OC_DMX_TAKEN) && (changed_q || have_write);
        out_d.last_result   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      s1_valid_q   <= 1'b0;
      s1_wr_sent_q <= 1'b0;
      changed_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      s1_valid_q   <= s1_valid_d;
      s1_wr_sent_q <= s1_wr_sent_d;
      changed_q    <= changed_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q    <= in_i.payload_byte;
      s1_cand_q    <= info.cand;
      s1_fresh_q   <= fresh;
      s1_last_q    <= in_i.end_of_packet;
      s1_idx_q     <= idx;
      s1_outcome_q <= info.outcome;
    end
    out_q <= out_d;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule
